// ===== hdl/snup_pkg.sv =====
`default_nettype none

package snup_pkg;

	// Field sizes and limits of the parser.
	localparam int UUID_BYTES = 16;
	localparam int SIZE_BITS  = 24;
	localparam int TYPE_BITS  = 16;
	localparam int UUID_CNT_W = $clog2(UUID_BYTES + 1);

	// Byte codes seen in the stream.
	localparam logic [7:0] START_BYTE    = 8'h01;
	localparam logic [7:0] EPB_BYTE      = 8'h03;
	localparam logic [7:0] EXT_BYTE      = 8'hFF;
	localparam logic [4:0] NAL_TYPE_SEI  = 5'h06;
	localparam logic [TYPE_BITS-1:0] SEI_TYPE_UNREG = TYPE_BITS'(5);

	typedef enum logic [3:0] {
		PH_SYNC,
		PH_HEAD,
		PH_TYPE,
		PH_SIZE,
		PH_UUID,
		PH_BODY,
		PH_TAIL,
		PH_SHORT,
		PH_FAIL
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_START   = 3'd1,
		ST_NOT_SEI    = 3'd2,
		ST_TRUNC_HEAD = 3'd3,
		ST_TOO_LONG   = 3'd4,
		ST_UUID_SHORT = 3'd5
	} status_t;

	// One result transaction as it leaves the parser core.
	typedef struct packed {
		logic [7:0]           out_byte;
		logic                 byte_valid;
		logic                 is_uuid_byte;
		logic [TYPE_BITS-1:0] sei_type;
		logic                 done_res;
		status_t              status;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/snup_in_if.sv =====
`default_nettype none

interface snup_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] nal_byte;
	logic       final_byte;

	modport source (output valid, output nal_byte, output final_byte, input ready);
	modport sink (input valid, input nal_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/snup_out_if.sv =====
`default_nettype none

interface snup_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        is_uuid_byte;
	logic [15:0] sei_type;
	logic        done_res;
	logic [2:0]  status;

	modport source (output valid, output out_byte, output byte_valid, output is_uuid_byte,
		output sei_type, output done_res, output status, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input is_uuid_byte,
		input sei_type, input done_res, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/sei_nal_unit_parser.sv =====
`default_nettype none

// SEI NAL unit parser. Takes one raw Annex B byte per transaction, start code included,
// with final_byte on the last byte of the unit, and returns a result transaction for
// every UUID or payload byte it extracts and for the final byte (done_res with status).
// Emulation-prevention bytes are removed and only the first SEI message is handled.
// A new byte is accepted in every cycle unless a held result waits on a stalled output;
// a byte passes through the input register and then the parser step, which fills the result
// register. Bytes that yield no result simply disappear inside the pipe. The parser
// returns to its reset state after each final byte, ready for the next unit.

module sei_nal_unit_parser import snup_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	snup_in_if.sink   nal,
	snup_out_if.source sei
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       v_s2;
	result_t    res_s2;
	logic       advance;
	logic       has_result;
	result_t    result;

	// The parser step runs when a byte is held in the input register and the result register can take its outcome.
	assign advance   = v_s1 && (!v_s2 || sei.ready);
	assign nal.ready = !v_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (nal.ready) begin
			v_s1 <= nal.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (nal.ready && nal.valid) begin
			byte_s1 <= nal.nal_byte;
			last_s1 <= nal.final_byte;
		end
	end

	snup_parse_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.nal_byte   (byte_s1),
		.final_byte (last_s1),
		.has_result (has_result),
		.result     (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= has_result;
		end else if (sei.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_s2 <= result;
		end
	end

	assign sei.valid        = v_s2;
	assign sei.out_byte     = res_s2.out_byte;
	assign sei.byte_valid   = res_s2.byte_valid;
	assign sei.is_uuid_byte = res_s2.is_uuid_byte;
	assign sei.sei_type     = res_s2.sei_type;
	assign sei.done_res     = res_s2.done_res;
	assign sei.status       = res_s2.status;

	// A result carries either an extracted byte or the end of the unit.
	a_result_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		sei.valid |-> (sei.byte_valid || sei.done_res))
		else $error("result transaction with neither byte nor done");

	// A status is reported only with done.
	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(sei.valid && !sei.done_res) |-> (sei.status == ST_OK))
		else $error("nonzero status without done");

	// A UUID tag never appears without an extracted byte.
	a_uuid_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(sei.valid && sei.is_uuid_byte) |-> sei.byte_valid)
		else $error("UUID tag on a result without a byte");

endmodule

`default_nettype wire

// ===== hdl/snup_parse_core.sv =====
`default_nettype none

module snup_parse_core import snup_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step_en,
	input  wire logic [7:0] nal_byte,
	input  wire logic       final_byte,
	output logic            has_result,
	output result_t         result
);

	phase_t                 phase_q, phase_u;
	logic [1:0]             zero_run_q, zero_run_u;
	logic [TYPE_BITS-1:0]   type_q, type_u;
	logic [SIZE_BITS-1:0]   size_q, size_u;
	logic [SIZE_BITS-1:0]   left_q, left_u;
	logic [UUID_CNT_W-1:0]  uuid_cnt_q, uuid_cnt_u;
	status_t                err_q, err_u;

	logic                   in_payload;
	logic                   drop;
	logic [TYPE_BITS:0]     type_sum;
	logic [SIZE_BITS:0]     size_sum;
	logic [SIZE_BITS-1:0]   left_dec;
	logic                   emit;
	logic                   is_uuid;
	status_t                status;

	// Phases in which emulation-prevention bytes are tracked and removed.
	assign in_payload = (phase_q == PH_TYPE) || (phase_q == PH_SIZE) ||
		(phase_q == PH_UUID) || (phase_q == PH_BODY) || (phase_q == PH_SHORT);
	assign drop     = in_payload && (nal_byte == EPB_BYTE) && (zero_run_q >= 2'd2);
	assign type_sum = {1'b0, type_q} + (TYPE_BITS + 1)'(nal_byte);
	assign size_sum = {1'b0, size_q} + (SIZE_BITS + 1)'(nal_byte);
	assign left_dec = left_q - SIZE_BITS'(1);

	// Next state of the parser after this byte, before the end-of-unit reset.
	always_comb begin
		phase_u    = phase_q;
		zero_run_u = zero_run_q;
		type_u     = type_q;
		size_u     = size_q;
		left_u     = left_q;
		uuid_cnt_u = uuid_cnt_q;
		err_u      = err_q;
		unique case (phase_q)
			PH_SYNC: begin
				if (nal_byte == 8'h00 && zero_run_q != 2'd3) begin
					zero_run_u = zero_run_q + 2'd1;
				end else if (nal_byte == START_BYTE && zero_run_q >= 2'd2) begin
					phase_u    = PH_HEAD;
					zero_run_u = '0;
				end else begin
					phase_u = PH_FAIL;
					err_u   = ST_NO_START;
				end
			end
			PH_HEAD: begin
				if (nal_byte[4:0] == NAL_TYPE_SEI) begin
					phase_u    = PH_TYPE;
					zero_run_u = '0;
				end else begin
					phase_u = PH_FAIL;
					err_u   = ST_NOT_SEI;
				end
			end
			PH_TYPE, PH_SIZE, PH_UUID, PH_BODY, PH_SHORT: begin
				// Zero-run tracking for emulation prevention.
				if (drop) begin
					zero_run_u = '0;
				end else if (nal_byte == 8'h00) begin
					if (zero_run_q < 2'd2) begin
						zero_run_u = zero_run_q + 2'd1;
					end
				end else begin
					zero_run_u = '0;
				end
				if (!drop) begin
					case (phase_q)
						PH_TYPE: begin
							type_u = type_sum[TYPE_BITS] ? '1 : type_sum[TYPE_BITS-1:0];
							if (nal_byte != EXT_BYTE) begin
								phase_u = PH_SIZE;
							end
						end
						PH_SIZE: begin
							size_u = size_sum[SIZE_BITS] ? '1 : size_sum[SIZE_BITS-1:0];
							if (nal_byte != EXT_BYTE) begin
								left_u = size_u;
								if (type_q == SEI_TYPE_UNREG) begin
									phase_u = (size_u < SIZE_BITS'(UUID_BYTES)) ?
										PH_SHORT : PH_UUID;
								end else begin
									phase_u = (size_u == '0) ? PH_TAIL : PH_BODY;
								end
							end
						end
						PH_SHORT: begin
							if (left_q != '0) begin
								left_u = left_dec;
							end
						end
						PH_UUID: begin
							left_u = left_dec;
							if (uuid_cnt_q == UUID_CNT_W'(UUID_BYTES - 1)) begin
								uuid_cnt_u = '0;
								phase_u    = (left_dec == '0) ? PH_TAIL : PH_BODY;
							end else begin
								uuid_cnt_u = uuid_cnt_q + UUID_CNT_W'(1);
							end
						end
						default: begin
							left_u = left_dec;
							if (left_dec == '0) begin
								phase_u = PH_TAIL;
							end
						end
					endcase
				end
			end
			default: begin
				// Failed or past the payload: bytes are ignored.
			end
		endcase
	end

	// Outputs of the step: extracted byte and end-of-unit status.
	always_comb begin
		emit    = !drop && ((phase_q == PH_UUID) || (phase_q == PH_BODY));
		is_uuid = !drop && (phase_q == PH_UUID);
		status  = ST_OK;
		if (final_byte) begin
			unique case (phase_u)
				PH_SYNC, PH_HEAD: status = ST_NO_START;
				PH_TYPE, PH_SIZE: status = ST_TRUNC_HEAD;
				PH_SHORT:         status = (left_u != '0) ? ST_TOO_LONG : ST_UUID_SHORT;
				PH_FAIL:          status = err_u;
				default:          status = (left_u != '0) ? ST_TOO_LONG : ST_OK;
			endcase
		end
		has_result          = step_en && (emit || final_byte);
		result.out_byte     = emit ? nal_byte : 8'h00;
		result.byte_valid   = emit;
		result.is_uuid_byte = is_uuid;
		result.sei_type     = type_u;
		result.done_res     = final_byte;
		result.status       = status;
	end

	// Parser state; the last byte of a unit returns it to the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SYNC;
			zero_run_q <= '0;
			type_q     <= '0;
			size_q     <= '0;
			left_q     <= '0;
			uuid_cnt_q <= '0;
			err_q      <= ST_OK;
		end else if (step_en) begin
			if (final_byte) begin
				phase_q    <= PH_SYNC;
				zero_run_q <= '0;
				type_q     <= '0;
				size_q     <= '0;
				left_q     <= '0;
				uuid_cnt_q <= '0;
				err_q      <= ST_OK;
			end else begin
				phase_q    <= phase_u;
				zero_run_q <= zero_run_u;
				type_q     <= type_u;
				size_q     <= size_u;
				left_q     <= left_u;
				uuid_cnt_q <= uuid_cnt_u;
				err_q      <= err_u;
			end
		end
	end

endmodule

`default_nettype wire
